### rtl/stngf_pkg.sv
// Shared types and constants for the segment table gap finder.
`timescale 1ns / 1ps
package stngf_pkg;

  localparam int unsigned FIELD_BITS = 48;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_OVERLAP = 3'd3,
    ST_NOGAP   = 3'd4
  } status_t;

  localparam logic [1:0] CFG_PAGE_SHIFT  = 2'd0;
  localparam logic [1:0] CFG_SPACE_START = 2'd1;
  localparam logic [1:0] CFG_SPACE_END   = 2'd2;

  localparam logic [4:0] PAGE_SHIFT_MAX = 5'd20;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [FIELD_BITS-1:0] address;
    logic [FIELD_BITS-1:0] length;
    logic [3:0]            permissions;
  } in_item_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [FIELD_BITS-1:0] placement;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // capture item, compute prechecks
    logic scan;     // examine entry/gap at scan index
    logic insert;   // shift and insert new segment
    logic clear;    // empty the table
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;  // current scan step is the final one
  } dp_sts_t;

endpackage

### rtl/stngf_datapath.sv
// Datapath: segment table, bounds, per-entry overlap and gap evaluation.
`timescale 1ns / 1ps
module stngf_datapath #(
  parameter int unsigned SEGMENTS  = 8,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,
  input  stngf_pkg::in_item_t item,
  input  logic [4:0]          page_shift,
  input  logic [stngf_pkg::FIELD_BITS-1:0] space_start,
  input  logic [stngf_pkg::FIELD_BITS-1:0] space_end,
  input  stngf_pkg::dp_cmd_t  cmd,
  output stngf_pkg::dp_sts_t  sts,
  output stngf_pkg::out_item_t result
);
  localparam int unsigned IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(SEGMENTS + 1);
  localparam int unsigned FB = stngf_pkg::FIELD_BITS;
  // working width: addresses plus carry
  localparam int unsigned W  = ADDR_BITS + 1;

  logic [ADDR_BITS-1:0] base_r   [SEGMENTS];
  logic [ADDR_BITS-1:0] len_r    [SEGMENTS];
  logic [3:0]           perm_r   [SEGMENTS];
  logic [SEGMENTS-1:0]  used_r;

  logic [1:0]           op_r;
  logic [ADDR_BITS-1:0] addr_r, want_r, rl_r, lo_r, hi_r;
  logic [3:0]           pin_r;
  logic [2:0]           st_r;
  logic [CW-1:0]        idx_r, pos_r, cnt_r;
  logic                 found_r;
  logic [ADDR_BITS-1:0] best_r, bdiff_r;

  // ---------------- prechecks (load cycle) ----------------
  logic [4:0]           shf;
  logic [ADDR_BITS-1:0] pmask, a_in, l_in, s_in, e_in, rem, addv, rl_c, lo_c, hi_c;
  logic                 rl_ok, b_ok;
  logic [W-1:0]         rl_sum, lo_sum;
  always_comb begin
    shf   = (page_shift > stngf_pkg::PAGE_SHIFT_MAX) ? stngf_pkg::PAGE_SHIFT_MAX : page_shift;
    pmask = (ADDR_BITS'(1) << shf) - ADDR_BITS'(1);
    a_in  = ADDR_BITS'(item.address);
    l_in  = ADDR_BITS'(item.length);
    s_in  = ADDR_BITS'(space_start);
    e_in  = ADDR_BITS'(space_end);
    rem   = l_in & pmask;
    addv  = (pmask - rem) + ADDR_BITS'(1);
    rl_sum = {1'b0, l_in} + {1'b0, addv};
    rl_ok = (rem == '0) || !rl_sum[ADDR_BITS];
    rl_c  = (rem == '0) ? l_in : rl_sum[ADDR_BITS-1:0];
    lo_sum = {1'b0, s_in | pmask} + W'(1);
    b_ok  = 1'b1;
    lo_c  = s_in;
    if ((s_in & pmask) != '0) begin
      lo_c = lo_sum[ADDR_BITS-1:0];
      if (lo_sum[ADDR_BITS]) b_ok = 1'b0;
    end
    hi_c = e_in & ~pmask;
    if (hi_c <= lo_c) b_ok = 1'b0;
  end

  logic [CW-1:0] used_cnt;
  always_comb begin
    used_cnt = '0;
    for (int i = 0; i < SEGMENTS; i++)
      if (used_r[i]) used_cnt = used_cnt + CW'(1);
  end

  // ---------------- per-step evaluation ----------------
  logic [IW-1:0]        ix, ixm;
  logic [ADDR_BITS-1:0] eb, el, pb, pl;
  logic [W-1:0]         eend, nend, gs, ge, cand, room;
  logic                 ovl, fits;
  logic [ADDR_BITS-1:0] diff;
  always_comb begin
    ix   = idx_r[IW-1:0];
    ixm  = IW'(idx_r - CW'(1));
    eb   = base_r[ix];
    el   = len_r[ix];
    pb   = base_r[ixm];
    pl   = len_r[ixm];
    eend = {1'b0, eb} + {1'b0, el};
    nend = {1'b0, addr_r} + {1'b0, rl_r};
    ovl  = ({1'b0, addr_r} < eend) && ({1'b0, eb} < nend);
    gs   = (idx_r == '0) ? {1'b0, lo_r} : ({1'b0, pb} + {1'b0, pl});
    ge   = (idx_r == cnt_r) ? {1'b0, hi_r} : {1'b0, eb};
    if (gs < {1'b0, lo_r}) gs = {1'b0, lo_r};
    if (ge > {1'b0, hi_r}) ge = {1'b0, hi_r};
    room = ge - gs;
    fits = (ge > gs) && (room >= {1'b0, rl_r});
    if ({1'b0, want_r} < gs)                     cand = gs;
    else if ({1'b0, want_r} > ge - {1'b0, rl_r}) cand = ge - {1'b0, rl_r};
    else                                         cand = {1'b0, want_r};
    diff = (cand[ADDR_BITS-1:0] > addr_r) ? cand[ADDR_BITS-1:0] - addr_r
                                          : addr_r - cand[ADDR_BITS-1:0];
  end

  assign sts.scan_last = (op_r == stngf_pkg::CMD_QUERY) ? (idx_r >= cnt_r)
                       : (idx_r + CW'(1) >= cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.clear) begin
      used_r <= '0;
    end else if (cmd.insert && st_r == stngf_pkg::ST_OK) begin
      used_r <= (used_r << 1) | SEGMENTS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= item.cmd;
      addr_r  <= a_in;
      want_r  <= a_in & ~pmask;
      rl_r    <= rl_c;
      lo_r    <= lo_c;
      hi_r    <= hi_c;
      pin_r   <= item.permissions;
      cnt_r   <= used_cnt;
      idx_r   <= '0;
      pos_r   <= used_cnt;
      found_r <= 1'b0;
      best_r  <= '0;
      bdiff_r <= '0;
      unique case (item.cmd)
        stngf_pkg::CMD_ADD: begin
          if ((a_in & pmask) != '0 || l_in == '0 || !rl_ok || !b_ok ||
              a_in < lo_c || a_in > hi_c || rl_c > hi_c - a_in)
            st_r <= stngf_pkg::ST_INVALID;
          else if (used_cnt >= CW'(SEGMENTS))
            st_r <= stngf_pkg::ST_FULL;
          else
            st_r <= stngf_pkg::ST_OK;
        end
        stngf_pkg::CMD_QUERY: begin
          if (l_in == '0)            st_r <= stngf_pkg::ST_INVALID;
          else if (!rl_ok || !b_ok)  st_r <= stngf_pkg::ST_NOGAP;
          else                       st_r <= stngf_pkg::ST_OK;
        end
        stngf_pkg::CMD_CLEAR: st_r <= stngf_pkg::ST_OK;
        default:              st_r <= stngf_pkg::ST_INVALID;
      endcase
    end else if (cmd.scan) begin
      idx_r <= idx_r + CW'(1);
      if (op_r == stngf_pkg::CMD_ADD) begin
        if (idx_r < cnt_r && st_r == stngf_pkg::ST_OK) begin
          if (ovl) st_r <= stngf_pkg::ST_OVERLAP;
          if (eb > addr_r && pos_r == cnt_r) pos_r <= idx_r;
        end
      end else if (st_r == stngf_pkg::ST_OK && fits) begin
        if (!found_r || diff < bdiff_r) begin
          found_r <= 1'b1;
          best_r  <= cand[ADDR_BITS-1:0];
          bdiff_r <= diff;
        end
      end
    end
  end

  // Insert: shift entries at or above pos up by one.
  always_ff @(posedge clk) begin
    if (cmd.insert && st_r == stngf_pkg::ST_OK && op_r == stngf_pkg::CMD_ADD) begin
      for (int i = SEGMENTS - 1; i >= 0; i--) begin
        if (CW'(i) == pos_r) begin
          base_r[i] <= addr_r;
          len_r[i]  <= rl_r;
          perm_r[i] <= pin_r;
        end else if (CW'(i) > pos_r && i > 0) begin
          base_r[i] <= base_r[(i > 0) ? i - 1 : 0];
          len_r[i]  <= len_r[(i > 0) ? i - 1 : 0];
          perm_r[i] <= perm_r[(i > 0) ? i - 1 : 0];
        end
      end
    end
  end

  always_comb begin
    result.status    = st_r;
    result.placement = '0;
    if (op_r == stngf_pkg::CMD_QUERY && st_r == stngf_pkg::ST_OK) begin
      if (found_r) result.placement = FB'(best_r);
      else         result.status    = stngf_pkg::ST_NOGAP;
    end
  end

  // Occupancy stays packed at the front of the table.
  property p_packed;
    @(posedge clk) disable iff (!rst_n) ((used_r + 1'b1) & used_r) == '0;
  endproperty
  a_packed: assert property (p_packed) else $error("table occupancy not packed");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> used_r == '0) else $error("clear left entries");

  a_onecmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("conflicting datapath commands");
endmodule

### rtl/stngf_ctrl.sv
// Controller: sequences load, entry scan, insert or clear, and result strobe.
`timescale 1ns / 1ps
module stngf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         item_cmd,
  input  stngf_pkg::dp_sts_t sts,
  output stngf_pkg::dp_cmd_t cmd,
  output logic               busy,
  output logic               done
);
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_INSERT = 5'b00100,
    S_CLEAR  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   is_add_r, is_add_nxt;

  always_comb begin
    state_nxt  = state_r;
    is_add_nxt = is_add_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          is_add_nxt = (item_cmd == stngf_pkg::CMD_ADD);
          priority if (item_cmd == stngf_pkg::CMD_CLEAR)
            state_nxt = S_CLEAR;
          else if (item_cmd == stngf_pkg::CMD_RSVD)
            state_nxt = S_DONE;
          else
            state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) state_nxt = is_add_r ? S_INSERT : S_DONE;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_DONE;
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      is_add_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      is_add_r <= is_add_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !busy) else $error("done not followed by idle");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted command did not start");
  a_ins: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> done) else $error("insert not followed by result");
endmodule

### rtl/segment_table_nearest_gap_finder_unit.sv
// Top level of the segment table gap finder: config registers and glue.
`timescale 1ns / 1ps
// Usage
//   Input channel: drive in_item with start high; the command is taken at a
//   rising edge where start is high and busy is low. One command at a time.
//   Result channel: out_valid pulses for one cycle with out_item (status and
//   placement). The receiver cannot stall; it must take the result then.
//   Config channel: cfg_valid/cfg_ready write cfg_index/cfg_data; cfg_ready is
//   always high. Register 0 page_shift, 1 space_start, 2 space_end. Write only
//   while idle.
// Sequence (from the transfer edge to the edge that takes the result)
//   add:   load, then a scan of the n stored segments, one entry per cycle
//          (at least one scan step), then one insert state and the strobe.
//   query: load, then a scan of the n + 1 gaps, one per cycle, and the strobe.
//   clear: load, clear state and strobe; unknown commands: load and strobe.
//   busy is low again the cycle after the strobe; no new command is taken
//   while busy is high.
// Reset
//   rst_n synchronous, active low: table empty, page_shift 12,
//   space_start 4096, space_end 2^47.
module segment_table_nearest_gap_finder_unit #(
  parameter int unsigned SEGMENTS  = 8,
  parameter int unsigned ADDR_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  stngf_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output stngf_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [stngf_pkg::FIELD_BITS-1:0] cfg_data
);
  logic [4:0]                        page_shift_r;
  logic [stngf_pkg::FIELD_BITS-1:0]  space_start_r, space_end_r;
  stngf_pkg::dp_cmd_t                dcmd;
  stngf_pkg::dp_sts_t                dsts;

  assign cfg_ready = 1'b1;

  // Hold configuration; update on each transfer to a known index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_shift_r  <= 5'd12;
      space_start_r <= stngf_pkg::FIELD_BITS'(4096);
      space_end_r   <= stngf_pkg::FIELD_BITS'(1) << 47;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        stngf_pkg::CFG_PAGE_SHIFT:  page_shift_r  <= cfg_data[4:0];
        stngf_pkg::CFG_SPACE_START: space_start_r <= cfg_data;
        stngf_pkg::CFG_SPACE_END:   space_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  stngf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .item_cmd (in_item.cmd),
    .sts      (dsts),
    .cmd      (dcmd),
    .busy     (busy),
    .done     (out_valid)
  );

  stngf_datapath #(
    .SEGMENTS  (SEGMENTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .item        (in_item),
    .page_shift  (page_shift_r),
    .space_start (space_start_r),
    .space_end   (space_end_r),
    .cmd         (dcmd),
    .sts         (dsts),
    .result      (out_item)
  );
endmodule
